/* src/assert_macros.svh */
// Assertion macros for the block's RTL; only bash_ctrl.sv includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen once reset is released.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* src/bash_pkg.sv */
`default_nettype none
package bash_pkg;

	localparam int NWORDS  = 24;
	localparam int NROUNDS = 24;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       round;
		logic       emit;
		logic [4:0] rnd;
	} cmd_t;

	localparam logic [63:0] RC [NROUNDS] = '{
		64'h3BF5080AC8BA94B1, 64'hC1D1659C1BBD92F6, 64'h60E8B2CE0DDEC97B,
		64'hEC5FB8FE790FBC13, 64'hAA043DE6436706A7, 64'h8929FF6A5E535BFD,
		64'h98BF1E2C50C97550, 64'h4C5F8F162864BAA8, 64'h262FC78B14325D54,
		64'h1317E3C58A192EAA, 64'h098BF1E2C50C9755, 64'hD8EE19681D669304,
		64'h6C770CB40EB34982, 64'h363B865A0759A4C1, 64'hC73622B47C4C0ACE,
		64'h639B115A3E260567, 64'hEDE6693460F3DA1D, 64'hAAD8D5034F9935A0,
		64'h556C6A81A7CC9AD0, 64'h2AB63540D3E64D68, 64'h155B1AA069F326B4,
		64'h0AAD8D5034F9935A, 64'h0556C6A81A7CC9AD, 64'hDE8082CD72DEBC78
	};

	// New lane j of a row takes old lane SHx[j] of the source row.
	localparam logic [2:0] SH0 [8] = '{3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7, 3'd4, 3'd1};
	localparam logic [2:0] SH1 [8] = '{3'd7, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd0};
	localparam logic [2:0] SH2 [8] = '{3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6};

	localparam logic [5:0] M1_BASE = 6'd8;
	localparam logic [5:0] N1_BASE = 6'd53;
	localparam logic [5:0] M2_BASE = 6'd14;
	localparam logic [5:0] N2_BASE = 6'd1;

	// Rotation for column j: base * 7^j mod 64, evaluated for constant j.
	function automatic logic [5:0] rot_amt(input logic [5:0] base, input int j);
		logic [5:0] r;
		r = base;
		for (int k = 0; k < 8; k++) begin
			if (k < j) begin
				r = 6'(r * 6'd7);
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
		return (x << r) | (x >> (7'd64 - {1'b0, r}));
	endfunction

endpackage
`default_nettype wire

/* src/bash_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"
module bash_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               valid,
	output logic               last_out,
	output bash_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	localparam logic [4:0] CNT_LAST = 5'(bash_pkg::NWORDS - 1);

	logic [1:0] state_q;
	logic [4:0] cnt_q;
	logic       accept;

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign valid  = (state_q == ST_EMIT);
	assign last_out = valid && (cnt_q == CNT_LAST);

	assign cmd.load  = accept;
	assign cmd.round = (state_q == ST_ROUND);
	assign cmd.emit  = valid;
	assign cmd.rnd   = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (cnt_q == CNT_LAST) begin
							cnt_q   <= '0;
							state_q <= ST_ROUND;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_ROUND, ST_EMIT: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= (state_q == ST_ROUND) ? ST_EMIT : ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_full_load_starts, (accept && cnt_q == CNT_LAST) |=> (busy && !valid), "rounds did not follow the last word")
	`ASSERT_CLK(a_last_frees, last_out |=> !busy, "block not free after the last word")
	`ASSERT_NEVER(a_cmd_overlap, cmd.load && (cmd.round || cmd.emit), "load while the datapath is in use")
	`ASSERT_CLK(a_emit_follows_rounds, $rose(valid) |-> $past(cmd.round && cnt_q == CNT_LAST), "emit without 24 rounds")

endmodule
`default_nettype wire

/* src/bash_dp.sv */
`default_nettype none
module bash_dp (
	input  wire logic           clk,
	input  wire bash_pkg::cmd_t cmd,
	input  wire logic [63:0]    word_in,
	output logic [63:0]         word_out
);

	logic [63:0] s_q  [bash_pkg::NWORDS];
	logic [63:0] nxt  [bash_pkg::NWORDS];
	logic [63:0] ra   [8];
	logic [63:0] rb   [8];
	logic [63:0] rc   [8];

	// One S-box column per lane; all eight run side by side.
	for (genvar j = 0; j < 8; j++) begin : g_col
		localparam logic [5:0] M1 = bash_pkg::rot_amt(bash_pkg::M1_BASE, j);
		localparam logic [5:0] N1 = bash_pkg::rot_amt(bash_pkg::N1_BASE, j);
		localparam logic [5:0] M2 = bash_pkg::rot_amt(bash_pkg::M2_BASE, j);
		localparam logic [5:0] N2 = bash_pkg::rot_amt(bash_pkg::N2_BASE, j);
		logic [63:0] a, b, c, u0, t, u1, u2;
		always_comb begin
			a  = s_q[j];
			b  = s_q[8 + j];
			c  = s_q[16 + j];
			u0 = a ^ b ^ c;
			t  = b ^ bash_pkg::rotl(u0, N1);
			u1 = t ^ bash_pkg::rotl(a, M1);
			u2 = c ^ bash_pkg::rotl(t, N2) ^ bash_pkg::rotl(c, M2);
			rb[j] = u1 ^ (u0 | u2);
			rc[j] = u2 ^ (u0 & u1);
			ra[j] = u0 ^ (~u2 | u1);
		end
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			nxt[j]      = rb[bash_pkg::SH1[j]];
			nxt[8 + j]  = rc[bash_pkg::SH2[j]];
			nxt[16 + j] = ra[bash_pkg::SH0[j]];
		end
		nxt[bash_pkg::NWORDS - 1] = nxt[bash_pkg::NWORDS - 1] ^ bash_pkg::RC[cmd.rnd];
	end

	// A round replaces the whole state; loading shifts words in at the top; emitting shifts them out at word 0.
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			s_q <= nxt;
		end else if (cmd.load || cmd.emit) begin
			for (int i = 0; i < bash_pkg::NWORDS - 1; i++) begin
				s_q[i] <= s_q[i + 1];
			end
			s_q[bash_pkg::NWORDS - 1] <= word_in;
		end
	end

	assign word_out = s_q[0];

endmodule
`default_nettype wire

/* src/bash_f_sponge_permutation.sv */
// Load: one word per cycle while busy is low, 24 words per block.
// After the 24th word: 24 rounds (one round per cycle), then 24 output
// words, one word per cycle with valid high; last_out marks the 24th word.
// The output cannot be stalled.
// Reset (arst_n low) discards a partly loaded block and restarts loading at word 0.
`default_nettype none
module bash_f_sponge_permutation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] word_in,
	output logic             valid,
	output logic [63:0]      word_out,
	output logic             last_out
);

	bash_pkg::cmd_t cmd;

	bash_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.valid    (valid),
		.last_out (last_out),
		.cmd      (cmd)
	);

	bash_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.word_in  (word_in),
		.word_out (word_out)
	);

endmodule
`default_nettype wire

/* tb/sv/bash_f_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module bash_f_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [63:0] word_in,
	input  wire logic        valid,
	input  wire logic [63:0] word_out,
	input  wire logic        last_out,
	output int               fails,
	output int               pending
);

	localparam int BLOCK_WORDS = 24;
	localparam int ROUNDS      = 24;

	localparam logic [63:0] ROUND_KEYS [ROUNDS] = '{
		64'h3BF5080AC8BA94B1, 64'hC1D1659C1BBD92F6, 64'h60E8B2CE0DDEC97B,
		64'hEC5FB8FE790FBC13, 64'hAA043DE6436706A7, 64'h8929FF6A5E535BFD,
		64'h98BF1E2C50C97550, 64'h4C5F8F162864BAA8, 64'h262FC78B14325D54,
		64'h1317E3C58A192EAA, 64'h098BF1E2C50C9755, 64'hD8EE19681D669304,
		64'h6C770CB40EB34982, 64'h363B865A0759A4C1, 64'hC73622B47C4C0ACE,
		64'h639B115A3E260567, 64'hEDE6693460F3DA1D, 64'hAAD8D5034F9935A0,
		64'h556C6A81A7CC9AD0, 64'h2AB63540D3E64D68, 64'h155B1AA069F326B4,
		64'h0AAD8D5034F9935A, 64'h0556C6A81A7CC9AD, 64'hDE8082CD72DEBC78
	};

	// Lane j of each new row is taken from lane LANE_FROM_x[j] of its source row.
	localparam int LANE_FROM_ROW0 [8] = '{6, 3, 0, 5, 2, 7, 4, 1};
	localparam int LANE_FROM_ROW1 [8] = '{7, 2, 1, 4, 3, 6, 5, 0};
	localparam int LANE_FROM_ROW2 [8] = '{1, 0, 3, 2, 5, 4, 7, 6};

	typedef struct packed {
		logic [63:0] data;
		logic        is_last;
	} out_word_t;

	out_word_t   expected_words [$];
	out_word_t   oldest;
	logic [63:0] block_words [BLOCK_WORDS];
	logic [4:0]  words_loaded;

	function automatic logic [63:0] rot64(input logic [63:0] x, input logic [5:0] r);
		if (r == 6'd0) begin
			return x;
		end
		return (x << r) | (x >> (64 - int'(r)));
	endfunction

	// Runs the full 24-round permutation in place on block_words.
	task automatic bash_f_apply();
		logic [63:0] a, b, c, u0, t, u1, u2;
		logic [5:0]  m1, n1, m2, n2;
		logic [63:0] prev [BLOCK_WORDS];
		for (int r = 0; r < ROUNDS; r++) begin
			m1 = 6'd8;
			n1 = 6'd53;
			m2 = 6'd14;
			n2 = 6'd1;
			for (int j = 0; j < 8; j++) begin
				a  = block_words[j];
				b  = block_words[8 + j];
				c  = block_words[16 + j];
				u0 = a ^ b ^ c;
				t  = b ^ rot64(u0, n1);
				u1 = t ^ rot64(a, m1);
				u2 = c ^ rot64(t, n2) ^ rot64(c, m2);
				block_words[8 + j]  = u1 ^ (u0 | u2);
				block_words[16 + j] = u2 ^ (u0 & u1);
				block_words[j]      = u0 ^ (~u2 | u1);
				m1 = m1 * 6'd7;
				n1 = n1 * 6'd7;
				m2 = m2 * 6'd7;
				n2 = n2 * 6'd7;
			end
			prev = block_words;
			for (int j = 0; j < 8; j++) begin
				block_words[j]      = prev[8 + LANE_FROM_ROW1[j]];
				block_words[8 + j]  = prev[16 + LANE_FROM_ROW2[j]];
				block_words[16 + j] = prev[LANE_FROM_ROW0[j]];
			end
			block_words[23] ^= ROUND_KEYS[r];
		end
	endtask

	// Both counters are two-state and start at zero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_loaded = 5'd0;
			expected_words.delete();
			pending = 0;
		end else begin
			if (start && !busy) begin
				block_words[words_loaded] = word_in;
				if (words_loaded == 5'(BLOCK_WORDS - 1)) begin
					words_loaded = 5'd0;
					bash_f_apply();
					for (int k = 0; k < BLOCK_WORDS; k++) begin
						expected_words.push_back('{block_words[k], k == BLOCK_WORDS - 1});
					end
				end else begin
					words_loaded = words_loaded + 5'd1;
				end
			end
			if (valid) begin
				if (expected_words.size() == 0) begin
					$error("unexpected transaction: word_out %h last_out %b", word_out, last_out);
					fails++;
				end else begin
					oldest = expected_words.pop_front();
					if (word_out !== oldest.data) begin
						$error("word_out: expected %h, actual %h", oldest.data, word_out);
						fails++;
					end
					if (last_out !== oldest.is_last) begin
						$error("last_out: expected %b, actual %b", oldest.is_last, last_out);
						fails++;
					end
				end
			end
			pending = expected_words.size();
		end
	end

endmodule
`default_nettype wire

/* tb/sv/tb_bash_f_sponge_permutation.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_bash_f_sponge_permutation;

	localparam int BLOCK_WORDS   = 24;
	localparam int RANDOM_BLOCKS = 10;
	localparam int IDLE_MIX [3]  = '{0, 53, 18};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] word_in;
	logic        valid;
	logic [63:0] word_out;
	logic        last_out;
	int          fails;
	int          pending;
	int          idle_pct;

	bash_f_sponge_permutation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.word_in  (word_in),
		.valid    (valid),
		.word_out (word_out),
		.last_out (last_out)
	);

	bash_f_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.word_in  (word_in),
		.valid    (valid),
		.word_out (word_out),
		.last_out (last_out),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Mostly dense random words, with a share of sparse and saturated patterns.
	function automatic logic [63:0] next_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(9))
			0: w = 64'd1 << $urandom_range(63);
			1: w = ~(64'd1 << $urandom_range(63));
			2: w = w & {$urandom, $urandom} & {$urandom, $urandom};
			3: w = w | {$urandom, $urandom} | {$urandom, $urandom};
			default: ;
		endcase
		return w;
	endfunction

	// Holds start low for random gaps, then keeps it high until the transaction.
	task automatic send_word(input logic [63:0] w);
		while ($urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			word_in <= next_word();
			@(posedge clk);
		end
		start   <= 1'b1;
		word_in <= w;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		word_in  = 64'd0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < BLOCK_WORDS; k++) begin
			case (k)
				0: send_word(64'd0);
				1: send_word(~64'd0);
				2: send_word(64'd1);
				3: send_word(64'h8000_0000_0000_0000);
				4: send_word(64'h5555_5555_5555_5555);
				5: send_word(64'hAAAA_AAAA_AAAA_AAAA);
				6: send_word(64'h0123_4567_89AB_CDEF);
				7: send_word(~64'd0);
				default: send_word(next_word());
			endcase
		end
		drain();

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			idle_pct = IDLE_MIX[b % 3];
			for (int k = 0; k < BLOCK_WORDS; k++) begin
				send_word(next_word());
			end
		end
		drain();

		repeat (100) @(posedge clk);
		@(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
